// ----- hdl/cmyg_pkg.sv -----
// Shared types, constants and phase tables for the CMYG mosaic converter.
`default_nettype none
package cmyg_pkg;

	// Configuration register indexes
	localparam logic [1:0] CFG_X_PHASE      = 2'd0;
	localparam logic [1:0] CFG_Y_PHASE      = 2'd1;
	localparam logic [1:0] CFG_LINE_WIDTH   = 2'd2;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd3;

	localparam int          SAMPLE_W = 16;
	localparam int          SUM3_W   = SAMPLE_W + 2;
	localparam int          PROD_W   = 2 * SUM3_W;
	// floor(s/3) == (s * ceil(2^19/3)) >> 19 for every s below 2^19
	localparam int          DIV3_SHIFT = 19;
	localparam logic [SUM3_W-1:0] DIV3_MUL = SUM3_W'(174763);

	localparam logic [0:0]  X_PHASE_RST      = 1'b1;
	localparam logic [1:0]  Y_PHASE_RST      = 2'd2;
	localparam logic [12:0] LINE_WIDTH_RST   = 13'd4096;
	localparam logic [15:0] FRAME_HEIGHT_RST = 16'd4096;

	// Positions inside the 2x2 window
	typedef enum logic [1:0] {
		POS_CUR,
		POS_LEFT,
		POS_ABOVE,
		POS_ABOVE_LEFT
	} win_pos_t;

	typedef struct packed {
		win_pos_t yel;
		win_pos_t cya;
		win_pos_t mag;
	} color_sel_t;

	function automatic color_sel_t phase_sel(input logic [2:0] mode);
		color_sel_t s;
		unique case (mode)
			3'd0: s = '{yel: POS_LEFT,       cya: POS_CUR,        mag: POS_ABOVE};
			3'd1: s = '{yel: POS_CUR,        cya: POS_LEFT,       mag: POS_ABOVE_LEFT};
			3'd2: s = '{yel: POS_ABOVE_LEFT, cya: POS_ABOVE,      mag: POS_LEFT};
			3'd3: s = '{yel: POS_ABOVE,      cya: POS_ABOVE_LEFT, mag: POS_CUR};
			3'd4: s = '{yel: POS_LEFT,       cya: POS_CUR,        mag: POS_ABOVE_LEFT};
			3'd5: s = '{yel: POS_CUR,        cya: POS_LEFT,       mag: POS_ABOVE};
			3'd6: s = '{yel: POS_ABOVE_LEFT, cya: POS_ABOVE,      mag: POS_CUR};
			3'd7: s = '{yel: POS_ABOVE,      cya: POS_ABOVE_LEFT, mag: POS_LEFT};
			default: s = '{yel: POS_CUR, cya: POS_CUR, mag: POS_CUR};
		endcase
		return s;
	endfunction

	function automatic logic [SAMPLE_W-1:0] win_pick(
		input win_pos_t            pos,
		input logic [SAMPLE_W-1:0] cur,
		input logic [SAMPLE_W-1:0] left,
		input logic [SAMPLE_W-1:0] above,
		input logic [SAMPLE_W-1:0] above_left
	);
		logic [SAMPLE_W-1:0] v;
		unique case (pos)
			POS_CUR:        v = cur;
			POS_LEFT:       v = left;
			POS_ABOVE:      v = above;
			POS_ABOVE_LEFT: v = above_left;
			default:        v = cur;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/cmyg_ram.sv -----
// Generic single-clock RAM, one write port and one registered read port.
`default_nettype none
module cmyg_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire                                       clk,
	input  wire                                       we,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                          wdata,
	input  wire                                       re,
	input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// read-first: a read and write of the same entry returns the old data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cmyg_mosaic_to_rgb.sv -----
// Top level: streaming CMYG 2x2 demosaic to red, green, blue and luminance.
// Takes one raw sample per clock while in_stall is low and, once the pipeline is
// full, delivers one result per clock while out_stall is low; an accepted sample
// passes stage 1, stage 2 and the output register. Throughput is set by the
// line buffer, a RAM of MAX_WIDTH entries with one write and one registered
// read per cycle: each request reads the sample above it and overwrites that
// entry with itself. Samples in row 0 or column 0 of a frame produce no result.
// Downstream stall back-pressures the input only while the output register
// holds an untaken result and the internal stages are full. The line buffer is
// not cleared by reset; rows are valid once a full frame row has been written.
`default_nettype none
module cmyg_mosaic_to_rgb #(
	parameter int MAX_WIDTH = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	// configuration
	input  wire         cfg_we,
	input  wire  [1:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	// input samples
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [15:0] raw_sample,
	input  wire         frame_start,
	// output pixels
	output logic        out_valid,
	input  wire         out_stall,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue,
	output logic [15:0] luminance,
	output logic        row_end,
	output logic        frame_end
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int SW = cmyg_pkg::SAMPLE_W;

	// configuration registers
	logic        x_phase_q;
	logic [1:0]  y_phase_q;
	logic [12:0] line_width_q;
	logic [15:0] frame_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_phase_q      <= cmyg_pkg::X_PHASE_RST;
			y_phase_q      <= cmyg_pkg::Y_PHASE_RST;
			line_width_q   <= cmyg_pkg::LINE_WIDTH_RST;
			frame_height_q <= cmyg_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cmyg_pkg::CFG_X_PHASE:      x_phase_q      <= cfg_data[0];
				cmyg_pkg::CFG_Y_PHASE:      y_phase_q      <= cfg_data[1:0];
				cmyg_pkg::CFG_LINE_WIDTH:   line_width_q   <= cfg_data[12:0];
				cmyg_pkg::CFG_FRAME_HEIGHT: frame_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective last column / last row indexes
	logic [16:0] wm1;
	logic [15:0] hm1;

	always_comb begin
		if (line_width_q < 13'd2) begin
			wm1 = 17'd1;
		end else if ({4'd0, line_width_q} > 17'(MAX_WIDTH)) begin
			wm1 = 17'(MAX_WIDTH - 1);
		end else begin
			wm1 = {4'd0, line_width_q} - 17'd1;
		end
		if (frame_height_q < 16'd2) begin
			hm1 = 16'd1;
		end else begin
			hm1 = frame_height_q - 16'd1;
		end
	end

	// stage 0: position, line buffer access
	logic [AW-1:0] col_q;
	logic [15:0]   row_q;
	logic [AW-1:0] x;
	logic [15:0]   y;
	logic          last_col;
	logic          last_row;
	logic [2:0]    mode;
	logic          accept;

	always_comb begin
		x        = frame_start ? '0 : col_q;
		y        = frame_start ? 16'd0 : row_q;
		last_col = 17'(x) >= wm1;
		last_row = y >= hm1;
		mode     = {y[1:0] + y_phase_q, x[0] ^ x_phase_q};
	end

	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 16'd0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : y + 16'd1;
			end else begin
				col_q <= x + AW'(1);
				row_q <= y;
			end
		end
	end

	logic [SW-1:0] above;

	cmyg_ram #(
		.WIDTH (SW),
		.DEPTH (MAX_WIDTH)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.waddr (x),
		.wdata (raw_sample),
		.re    (accept),
		.raddr (x),
		.rdata (above)
	);

	// stage 1: window and color selection
	logic          v_s1;
	logic [SW-1:0] sample_s1;
	logic [2:0]    mode_s1;
	logic          emit_s1;
	logic          row_end_s1;
	logic          frame_end_s1;
	logic [SW-1:0] left_q;
	logic [SW-1:0] above_left_q;

	logic          v_s2;
	logic          adv1;
	logic          adv2;

	assign adv2     = v_s2 && (!out_valid || !out_stall);
	assign adv1     = v_s1 && (!emit_s1 || !v_s2 || adv2);
	assign in_stall = v_s1 && !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (adv1) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1    <= raw_sample;
			mode_s1      <= mode;
			emit_s1      <= (x != '0) && (y != 16'd0);
			row_end_s1   <= last_col;
			frame_end_s1 <= last_col && last_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q       <= '0;
			above_left_q <= '0;
		end else if (adv1) begin
			left_q       <= sample_s1;
			above_left_q <= above;
		end
	end

	cmyg_pkg::color_sel_t sel;
	logic [SW-1:0] yel;
	logic [SW-1:0] cya;
	logic [SW-1:0] mag;
	logic [SW:0]   my_sum;
	logic [SW:0]   cy_sum;
	logic [SW:0]   mc_sum;

	always_comb begin
		sel    = cmyg_pkg::phase_sel(mode_s1);
		yel    = cmyg_pkg::win_pick(sel.yel, sample_s1, left_q, above, above_left_q);
		cya    = cmyg_pkg::win_pick(sel.cya, sample_s1, left_q, above, above_left_q);
		mag    = cmyg_pkg::win_pick(sel.mag, sample_s1, left_q, above, above_left_q);
		my_sum = {1'b0, mag} + {1'b0, yel};
		cy_sum = {1'b0, cya} + {1'b0, yel};
		mc_sum = {1'b0, mag} + {1'b0, cya};
	end

	// stage 2: halves registered, luminance sum waits for the multiply
	logic [SW-1:0]                 red_s2;
	logic [SW-1:0]                 green_s2;
	logic [SW-1:0]                 blue_s2;
	logic [cmyg_pkg::SUM3_W-1:0]   sum3_s2;
	logic                          row_end_s2;
	logic                          frame_end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv1 && emit_s1) begin
			v_s2 <= 1'b1;
		end else if (adv2) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && emit_s1) begin
			red_s2       <= my_sum[SW:1];
			green_s2     <= cy_sum[SW:1];
			blue_s2      <= mc_sum[SW:1];
			sum3_s2      <= {1'b0, my_sum} + {2'b00, cya};
			row_end_s2   <= row_end_s1;
			frame_end_s2 <= frame_end_s1;
		end
	end

	// divide by three through the reciprocal
	logic [cmyg_pkg::PROD_W-1:0] lum_prod;

	assign lum_prod = cmyg_pkg::PROD_W'(sum3_s2) * cmyg_pkg::PROD_W'(cmyg_pkg::DIV3_MUL);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv2) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			red       <= red_s2;
			green     <= green_s2;
			blue      <= blue_s2;
			luminance <= lum_prod[cmyg_pkg::DIV3_SHIFT +: SW];
			row_end   <= row_end_s2;
			frame_end <= frame_end_s2;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/cmyg_checker.sv -----
// Port-level checker for the CMYG mosaic converter, bound to the top level.
`default_nettype none
module cmyg_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [15:0] red,
	input wire [15:0] green,
	input wire [15:0] blue,
	input wire [15:0] luminance,
	input wire        row_end,
	input wire        frame_end
);

	// a pending result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(red) && $stable(green) && $stable(blue)
			&& $stable(luminance) && $stable(row_end) && $stable(frame_end))
		else $error("stalled output payload changed");

	// the input is only held off by a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// the last pixel of a frame is also the last of its row
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> row_end)
		else $error("frame end without row end");

endmodule

bind cmyg_mosaic_to_rgb cmyg_checker u_cmyg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.red       (red),
	.green     (green),
	.blue      (blue),
	.luminance (luminance),
	.row_end   (row_end),
	.frame_end (frame_end)
);
`default_nettype wire
